/* src/edist_pkg.sv */
// ----------------------------------------------------------------------------
// edist_pkg
// Shared types and constants of the Euclidean distance block.
// ----------------------------------------------------------------------------
package edist_pkg;

	// Data widths
	localparam int COORD_BITS = 24;
	localparam int MAX_DIM    = 256;
	localparam int LEN_BITS   = 9;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int SUM_BITS   = 58;
	localparam int DIST_BITS  = SUM_BITS / 2;
	localparam int REM_BITS   = DIST_BITS + 2;
	localparam int STEP_BITS  = $clog2(DIST_BITS);

	// Sum queue between accumulator and root unit
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_LVL_BITS = Q_PTR_BITS + 1;

	// Finished sum handed to the queue
	typedef struct packed {
		logic                push;
		logic [SUM_BITS-1:0] sum;
	} q_push_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic                  empty;
		logic [Q_LVL_BITS-1:0] level;
	} q_stat_t;

	// Root unit states
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CALC = 3'b010,
		S_OUT  = 3'b100
	} back_state_t;

endpackage

/* src/edist_in_if.sv */
// ----------------------------------------------------------------------------
// edist_in_if
// Coordinate pair channel: valid/ready with two signed Q8.16 elements.
// ----------------------------------------------------------------------------
interface edist_in_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [edist_pkg::COORD_BITS-1:0]   coord_a;
	logic signed [edist_pkg::COORD_BITS-1:0]   coord_b;

	modport source(output valid, coord_a, coord_b, input ready);
	modport sink(input valid, coord_a, coord_b, output ready);
endinterface

/* src/edist_cfg_if.sv */
// ----------------------------------------------------------------------------
// edist_cfg_if
// Configuration write channel carrying the vector length.
// ----------------------------------------------------------------------------
interface edist_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [edist_pkg::LEN_BITS-1:0]    vector_length;

	modport source(output valid, vector_length, input ready);
	modport sink(input valid, vector_length, output ready);
endinterface

/* src/edist_out_if.sv */
// ----------------------------------------------------------------------------
// edist_out_if
// Result channel: valid/ready with an unsigned Q13.16 distance.
// ----------------------------------------------------------------------------
interface edist_out_if;
	logic                              valid;
	logic                              ready;
	logic [edist_pkg::DIST_BITS-1:0]   distance;

	modport source(output valid, distance, input ready);
	modport sink(input valid, distance, output ready);
endinterface

/* src/edist_front.sv */
// ----------------------------------------------------------------------------
// edist_front
// Takes coordinate pairs, squares the difference and accumulates it; pushes
// the finished sum of each vector into the queue.
// ----------------------------------------------------------------------------
module edist_front (
	input  logic                 clk,
	input  logic                 arst_n,
	edist_in_if.sink             pairs,
	edist_cfg_if.sink            cfg,
	input  edist_pkg::q_stat_t   stat,
	output edist_pkg::q_push_t   push
);

	localparam int CW = edist_pkg::COORD_BITS;
	localparam int LW = edist_pkg::LEN_BITS;
	localparam int QL = edist_pkg::Q_LVL_BITS;

	logic [LW-1:0]                   len_q;
	logic [LW-1:0]                   cnt_q;
	logic [LW-1:0]                   len_eff;
	logic                            accept;
	logic                            last;
	logic signed [CW:0]              diff;
	logic [CW:0]                     mag_full;
	logic [QL:0]                     pending;

	logic                            vld_s1;
	logic                            last_s1;
	logic [CW-1:0]                   mag_s1;
	logic                            vld_s2;
	logic                            last_s2;
	logic [edist_pkg::SQ_BITS-1:0]   sq_s2;
	logic [edist_pkg::SUM_BITS-1:0]  sum_q;
	logic [edist_pkg::SUM_BITS-1:0]  total;

	// Configuration register; the user must write it only while idle, the block itself does not enforce it
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(1);
		end else if (cfg.valid) begin
			len_q <= cfg.vector_length;
		end
	end

	// Clamp length to 1..MAX_DIM
	always_comb begin
		if (len_q == '0) begin
			len_eff = LW'(1);
		end else if (len_q > LW'(edist_pkg::MAX_DIM)) begin
			len_eff = LW'(edist_pkg::MAX_DIM);
		end else begin
			len_eff = len_q;
		end
	end

	// Only take a pair if every completion in flight still finds a queue slot
	assign pending = (QL+1)'(stat.level) + (QL+1)'(vld_s1 & last_s1)
		+ (QL+1)'(vld_s2 & last_s2);
	assign pairs.ready = (pending < (QL+1)'(edist_pkg::Q_DEPTH));
	assign accept      = pairs.valid & pairs.ready;
	assign last        = ({1'b0, cnt_q} + (LW+1)'(1)) >= {1'b0, len_eff};

	// Element counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= last ? '0 : cnt_q + LW'(1);
		end
	end

	// Stage 1: magnitude of the difference
	assign diff     = {pairs.coord_a[CW-1], pairs.coord_a} - {pairs.coord_b[CW-1], pairs.coord_b};
	assign mag_full = diff[CW] ? (~diff + (CW+1)'(1)) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1 <= mag_full[CW-1:0];
		end
	end

	// Stage 2: square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			sq_s2 <= mag_s1 * mag_s1;
		end
	end

	// Stage 3: accumulate, hand finished sum to the queue
	assign total = sum_q + {{(edist_pkg::SUM_BITS-edist_pkg::SQ_BITS){1'b0}}, sq_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (vld_s2) begin
			sum_q <= last_s2 ? '0 : total;
		end
	end

	assign push.push = vld_s2 & last_s2;
	assign push.sum  = total;

`ifndef SYNTH
	// Counter stays below MAX_DIM
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < LW'(edist_pkg::MAX_DIM))
		else $error("element counter out of range");
`endif

endmodule

/* src/edist_queue.sv */
// ----------------------------------------------------------------------------
// edist_queue
// Short FIFO of finished sums between accumulator and root unit.
// ----------------------------------------------------------------------------
module edist_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  edist_pkg::q_push_t                  push,
	input  logic                                pop,
	output logic [edist_pkg::SUM_BITS-1:0]      rd_sum,
	output edist_pkg::q_stat_t                  stat
);

	localparam int PW = edist_pkg::Q_PTR_BITS;
	localparam int QL = edist_pkg::Q_LVL_BITS;

	logic [edist_pkg::SUM_BITS-1:0] mem_q [edist_pkg::Q_DEPTH];
	logic [PW-1:0]                  wr_q;
	logic [PW-1:0]                  rd_q;
	logic [QL-1:0]                  level_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_q] <= push.sum;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push.push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push.push && !pop) begin
				level_q <= level_q + QL'(1);
			end else if (!push.push && pop) begin
				level_q <= level_q - QL'(1);
			end
		end
	end

	assign rd_sum     = mem_q[rd_q];
	assign stat.empty = (level_q == '0);
	assign stat.level = level_q;

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> (level_q < QL'(edist_pkg::Q_DEPTH)))
		else $error("push into full sum queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (level_q != '0))
		else $error("pop from empty sum queue");
`endif

endmodule

/* src/edist_back.sv */
// ----------------------------------------------------------------------------
// edist_back
// Integer square root of a queued sum, one result bit per cycle, and the
// output register.
// ----------------------------------------------------------------------------
module edist_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  edist_pkg::q_stat_t                  stat,
	input  logic [edist_pkg::SUM_BITS-1:0]      rd_sum,
	output logic                                pop,
	edist_out_if.source                         result
);

	localparam int SW = edist_pkg::SUM_BITS;
	localparam int DW = edist_pkg::DIST_BITS;
	localparam int RW = edist_pkg::REM_BITS;
	localparam int TW = RW + 2;
	localparam int NW = edist_pkg::STEP_BITS;

	edist_pkg::back_state_t state_q;
	logic [SW-1:0]          x_q;
	logic [RW-1:0]          rem_q;
	logic [DW-1:0]          root_q;
	logic [NW-1:0]          step_q;
	logic                   out_vld_q;
	logic [DW-1:0]          dist_q;
	logic [TW-1:0]          cur;
	logic [TW-1:0]          trial;
	logic                   fits;
	logic                   out_free;

	// One restoring step: bring down two bits, try (4*root + 1)
	assign cur      = {rem_q, x_q[SW-1 -: 2]};
	assign trial    = {{(TW-DW-2){1'b0}}, root_q, 2'b01};
	assign fits     = (cur >= trial);
	assign out_free = !out_vld_q || result.ready;
	assign pop      = (state_q == edist_pkg::S_IDLE) && !stat.empty;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= edist_pkg::S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				edist_pkg::S_IDLE: begin
					if (!stat.empty) begin
						state_q <= edist_pkg::S_CALC;
						step_q  <= NW'(DW - 1);
					end
				end
				edist_pkg::S_CALC: begin
					step_q <= step_q - NW'(1);
					if (step_q == '0) begin
						state_q <= edist_pkg::S_OUT;
					end
				end
				edist_pkg::S_OUT: begin
					if (out_free) begin
						state_q <= edist_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= edist_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Root datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			x_q    <= rd_sum;
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == edist_pkg::S_CALC) begin
			x_q <= {x_q[SW-3:0], 2'b00};
			if (fits) begin
				rem_q  <= RW'(cur - trial);
				root_q <= {root_q[DW-2:0], 1'b1};
			end else begin
				rem_q  <= cur[RW-1:0];
				root_q <= {root_q[DW-2:0], 1'b0};
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == edist_pkg::S_OUT && out_free) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == edist_pkg::S_OUT && out_free) begin
			dist_q <= root_q;
		end
	end

	assign result.valid    = out_vld_q;
	assign result.distance = dist_q;

`ifndef SYNTH
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == edist_pkg::S_CALC && step_q != '0)
		|=> (state_q == edist_pkg::S_CALC && step_q == $past(step_q) - NW'(1)))
		else $error("root step counter skipped");

	a_calc_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == edist_pkg::S_CALC && step_q == '0) |=> (state_q == edist_pkg::S_OUT))
		else $error("root unit missed its last step");
`endif

endmodule

/* src/euclidean_distance.sv */
// ----------------------------------------------------------------------------
// euclidean_distance
// Streaming Euclidean distance of two vectors given one pair per transfer.
//
// Channels: pairs takes one coord_a/coord_b pair (signed Q8.16) per transfer;
// cfg writes vector_length (1..256, 0 acts as 1, larger acts as 256); result
// gives one unsigned Q13.16 distance per completed vector.
// Pairs are taken at one per cycle while pairs.ready is high. Each pair runs
// through a difference stage, a 24x24 multiply stage and the 58-bit
// accumulator. The sum of a finished vector enters a four-entry queue; the
// root unit loads it, retires one result bit per cycle in S_CALC, passes the
// root through S_OUT into the output register that drives result.valid, and
// takes the next sum only once back in S_IDLE. Long vectors stream without a
// gap; short ones are limited by the root unit once the queue fills.
// A result waits in the output register while result.ready is low; the
// root unit finishes its current root and waits in S_OUT, the accumulator
// keeps working until the queue would be full, then pairs.ready drops.
// Reset clears the sum, the element count and the queue, and sets the
// vector length to 1.
// ----------------------------------------------------------------------------
module euclidean_distance (
	input  logic          clk,
	input  logic          arst_n,
	edist_in_if.sink      pairs,
	edist_cfg_if.sink     cfg,
	edist_out_if.source   result
);

	edist_pkg::q_push_t                  push;
	edist_pkg::q_stat_t                  stat;
	logic                                pop;
	logic [edist_pkg::SUM_BITS-1:0]      rd_sum;

	// Accumulator side
	edist_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pairs),
		.cfg    (cfg),
		.stat   (stat),
		.push   (push)
	);

	// Sum queue
	edist_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.rd_sum (rd_sum),
		.stat   (stat)
	);

	// Root side
	edist_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.rd_sum (rd_sum),
		.pop    (pop),
		.result (result)
	);

endmodule

/* test/tb_euclidean_distance.sv */
// ----------------------------------------------------------------------------
// tb_euclidean_distance
// Self-checking bench for the streaming Euclidean distance block.
//
// Coordinate pairs are queued by the stimulus process and handed out by a
// clocked driver. At every accepted transfer the driver runs a local model of
// the accumulator, which predicts the distance of each vector it completes.
// A clocked monitor takes results with random back-pressure and compares
// each one with the oldest prediction. The vector length is only rewritten
// once the block has gone quiet. The run covers full-scale and
// mid-vector length changes, and sender and receiver gaps.
// ----------------------------------------------------------------------------
module tb_euclidean_distance;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS = edist_pkg::COORD_BITS;
	localparam int DIST_BITS  = edist_pkg::DIST_BITS;
	localparam int SUM_BITS   = edist_pkg::SUM_BITS;
	localparam int LEN_BITS   = edist_pkg::LEN_BITS;
	localparam int MAX_DIM    = edist_pkg::MAX_DIM;

	localparam logic signed [COORD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = 24'sh800000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1150;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a;
		logic signed [COORD_BITS-1:0] b;
	} pair_t;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// bench-side drive values, known from time zero
	logic                         pair_valid = 1'b0;
	logic signed [COORD_BITS-1:0] pair_a     = '0;
	logic signed [COORD_BITS-1:0] pair_b     = '0;
	logic                         cfg_valid  = 1'b0;
	logic [LEN_BITS-1:0]          cfg_len    = '0;
	logic                         res_ready  = 1'b0;

	edist_in_if  pairs_if();
	edist_cfg_if cfg_if();
	edist_out_if result_if();

	assign pairs_if.valid        = pair_valid;
	assign pairs_if.coord_a      = pair_a;
	assign pairs_if.coord_b      = pair_b;
	assign cfg_if.valid          = cfg_valid;
	assign cfg_if.vector_length  = cfg_len;
	assign result_if.ready       = res_ready;

	euclidean_distance dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pairs_if),
		.cfg    (cfg_if),
		.result (result_if)
	);

	// Stimulus and prediction state
	pair_t                 pair_backlog[$];
	logic [DIST_BITS-1:0]  pending_distances[$];
	logic [SUM_BITS-1:0]   sum_of_squares = '0;
	int unsigned           elements_held  = 0;
	logic [LEN_BITS-1:0]   vector_len     = 9'd1;
	int unsigned           pairs_queued   = 0;
	int unsigned           pairs_taken    = 0;
	int unsigned           send_idle_pct  = 0;
	int unsigned           recv_stall_pct = 0;
	int unsigned           errors         = 0;

	initial forever #1 clk = ~clk;

	task automatic flag_error(string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	// floor of the square root, one result bit per trial
	function automatic logic [DIST_BITS-1:0] floor_root(logic [SUM_BITS-1:0] x);
		logic [DIST_BITS-1:0] root;
		logic [DIST_BITS-1:0] trial;
		root = '0;
		for (int i = DIST_BITS - 1; i >= 0; i--) begin
			trial = root | (DIST_BITS'(1) << i);
			if (64'(trial) * 64'(trial) <= 64'(x))
				root = trial;
		end
		return root;
	endfunction

	// Add one pair to the running sum; predict a distance when the vector closes
	function automatic void accumulate_pair(logic signed [COORD_BITS-1:0] a,
			logic signed [COORD_BITS-1:0] b);
		logic signed [COORD_BITS:0] diff;
		logic [COORD_BITS:0]        mag;
		logic [SUM_BITS-1:0]        square;
		int unsigned                lim;
		diff = a - b;
		if (diff < 0)
			mag = -diff;
		else
			mag = diff;
		square = mag * mag;
		// zero acts as one, anything past the maximum as the maximum
		if (vector_len == 0)
			lim = 1;
		else if (vector_len > MAX_DIM)
			lim = MAX_DIM;
		else
			lim = vector_len;
		sum_of_squares = sum_of_squares + square;
		elements_held++;
		if (elements_held >= lim) begin
			pending_distances.push_back(floor_root(sum_of_squares));
			sum_of_squares = '0;
			elements_held  = 0;
		end
	endfunction

	function automatic logic signed [COORD_BITS-1:0] random_coord();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return COORD_MAX;
		else if (pick < 16)
			return COORD_MIN;
		else if (pick < 24)
			return COORD_BITS'(int'($urandom_range(0, 64)) - 32);
		return COORD_BITS'($urandom);
	endfunction

	task automatic push_pair(logic signed [COORD_BITS-1:0] a,
			logic signed [COORD_BITS-1:0] b);
		pair_t p;
		p.a = a;
		p.b = b;
		pair_backlog.push_back(p);
		pairs_queued++;
	endtask

	task automatic push_random(int unsigned n);
		repeat (n) push_pair(random_coord(), random_coord());
	endtask

	// Wait until every queued pair is taken and every distance has come out
	task automatic settle();
		while (pairs_taken != pairs_queued || pending_distances.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Length register write, only once the block is quiet
	task automatic write_length(logic [LEN_BITS-1:0] len);
		settle();
		cfg_valid <= 1'b1;
		cfg_len   <= len;
		do
			@(posedge clk);
		while (cfg_if.ready !== 1'b1);
		cfg_valid  <= 1'b0;
		vector_len = len;
	endtask

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct  = 62;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct = 62;
			end
			default: begin
				send_idle_pct  = 17;
				recv_stall_pct = 17;
			end
		endcase
	endtask

	// Pair driver: account for the transfer, then offer the next pair
	always @(posedge clk or negedge arst_n) begin : drive_pairs
		pair_t nxt;
		if (!arst_n) begin
			pair_valid <= 1'b0;
		end else begin
			if (pair_valid && pairs_if.ready === 1'b1) begin
				accumulate_pair(pairs_if.coord_a, pairs_if.coord_b);
				pairs_taken++;
			end
			if (!pair_valid || pairs_if.ready === 1'b1) begin
				if (pair_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pair_backlog.pop_front();
					pair_valid <= 1'b1;
					pair_a     <= nxt.a;
					pair_b     <= nxt.b;
				end else begin
					pair_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_results
		logic [DIST_BITS-1:0] want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (result_if.valid === 1'b1 && res_ready) begin
				if (pending_distances.size() == 0) begin
					flag_error($sformatf("unexpected distance %0d", result_if.distance));
				end else begin
					want = pending_distances.pop_front();
					if (result_if.distance !== want)
						flag_error($sformatf("distance %0d, predicted %0d",
							result_if.distance, want));
				end
			end
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus sequence
	initial begin : stimulus
		int unsigned         random_items;
		int unsigned         phase;
		int unsigned         pick;
		int unsigned         eff;
		int unsigned         vectors;
		int unsigned         n;
		logic [LEN_BITS-1:0] len;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length 1 out of reset: single-element vectors at the extremes
		push_pair('0, '0);
		push_pair(COORD_MAX, COORD_MIN);
		push_pair(COORD_MIN, COORD_MAX);
		push_pair(COORD_MIN, COORD_MIN);
		push_pair(COORD_MAX, COORD_MAX);
		push_pair(-24'sd1, '0);
		push_pair('0, 24'sd1);
		push_pair(24'sh555555, 24'shAAAAAA);
		push_pair(24'sd1, -24'sd1);

		// zero length behaves as one
		write_length('0);
		push_pair(24'sd3, '0);
		push_pair('0, COORD_MIN);

		// four full-scale elements
		write_length(9'd4);
		repeat (2) begin
			push_pair(COORD_MAX, COORD_MIN);
			push_pair(COORD_MIN, COORD_MAX);
		end

		// length shortened below the count already held
		write_length(9'd8);
		push_random(5);
		write_length(9'd3);
		push_random(1);

		// length shortened to exactly the count already held
		write_length(9'd8);
		push_random(3);
		write_length(9'd3);
		push_random(1);

		// Random phases, idling pattern rotating per phase
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			set_idling(idle_mode_t'(phase % 4));
			if (phase == 2) begin
				// oversize length, full-scale vector for the largest sum
				write_length(9'd511);
				repeat (MAX_DIM / 2) begin
					push_pair(COORD_MAX, COORD_MIN);
					push_pair(COORD_MIN, COORD_MAX);
				end
				random_items += MAX_DIM;
			end else begin
				if (phase == 5) begin
					len = 9'(MAX_DIM);
				end else begin
					pick = $urandom_range(99);
					if (pick < 45)
						len = 9'($urandom_range(1, 4));
					else if (pick < 75)
						len = 9'($urandom_range(5, 12));
					else if (pick < 88)
						len = 9'($urandom_range(13, 40));
					else if (pick < 93)
						len = '0;
					else if (pick < 96)
						len = 9'(MAX_DIM - 1);
					else
						len = 9'($urandom_range(MAX_DIM + 1, 511));
				end
				write_length(len);
				if (len == 0)
					eff = 1;
				else if (len > MAX_DIM)
					eff = MAX_DIM;
				else
					eff = len;
				if (eff <= 12)
					vectors = $urandom_range(6, 20);
				else if (eff <= 40)
					vectors = $urandom_range(2, 4);
				else
					vectors = 1;
				n = vectors * eff;
				// sometimes leave a partial vector to run into the next length
				if ($urandom_range(3) == 0)
					n += $urandom_range(0, eff - 1);
				push_random(n);
				random_items += n;
			end
			phase++;
		end

		set_idling(IDLE_NONE);
		settle();
		if (errors == 0)
			$display("tb_euclidean_distance OK");
		else
			$display("tb_euclidean_distance NOT OK");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("tb_euclidean_distance NOT OK");
		$finish;
	end

endmodule

/* euclidean_distance.f */
src/edist_pkg.sv
src/edist_in_if.sv
src/edist_cfg_if.sv
src/edist_out_if.sv
src/edist_front.sv
src/edist_queue.sv
src/edist_back.sv
src/euclidean_distance.sv
test/tb_euclidean_distance.sv
